FILE: rtl/core/ppd_pkg.sv
// Shared types and constants for the point pair heading pipeline.
`default_nettype none

package ppd_pkg;

  // Coordinate and fixed-point geometry
  localparam int COORD_BITS = 12;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int FRAC       = 16;
  // CORDIC x/y: magnitude below 2^COORD_BITS, scaled by 2^FRAC, gain ~1.65, sqrt(2), sign
  localparam int CW         = COORD_BITS + FRAC + 3;
  // Angle accumulator; also holds 360 degrees in Q16 plus the rounding half
  localparam int ZW         = 25;
  localparam int HEAD_BITS  = 9;

  localparam int STEPS           = 16;
  localparam int STEPS_PER_STAGE = 4;

  localparam logic [ZW-1:0] A90_Q16    = ZW'(5898674);
  localparam logic [ZW-1:0] HALF_Q16   = ZW'(32768);
  localparam logic [ZW-1:0] D180_ROUND = ZW'((180 << FRAC) + 32768);
  localparam logic [ZW-1:0] D360_ROUND = ZW'((360 << FRAC) + 32768);

  // round(atan(2^-i) * 57.3 * 2^16)
  localparam logic [ZW-1:0] STEP_ANGLE [STEPS] = '{
    ZW'(2949337), ZW'(1741095), ZW'(919947), ZW'(466979),
    ZW'(234396),  ZW'(117312),  ZW'(58670),  ZW'(29337),
    ZW'(14669),   ZW'(7334),    ZW'(3667),   ZW'(1834),
    ZW'(917),     ZW'(458),     ZW'(229),    ZW'(115)
  };

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
  } pair_t;

  typedef struct packed {
    logic [HEAD_BITS-1:0] heading_deg;
    logic                 degenerate;
  } heading_t;

  // Per-transaction flags carried alongside the CORDIC data
  typedef struct packed {
    logic degenerate;  // points coincide
    logic ax_zero;     // vertical pair, angle forced to zero
    logic ay_zero;     // horizontal pair, angle forced to 90
    logic dx_neg;      // first_x < second_x
    logic dy_pos;      // first_y > second_y
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/ppd_prep.sv
// Input stage: differences, magnitudes, quadrant flags and CORDIC seed.
`default_nettype none

module ppd_prep (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic                          valid_in,
  input  wire ppd_pkg::pair_t                pair_in,
  output logic                               valid,
  output ppd_pkg::ctrl_t                     ctrl,
  output logic signed [ppd_pkg::CW-1:0]      x,
  output logic signed [ppd_pkg::CW-1:0]      y
);

  logic signed [ppd_pkg::DIFF_BITS-1:0]  dx;
  logic signed [ppd_pkg::DIFF_BITS-1:0]  dy;
  logic signed [ppd_pkg::DIFF_BITS-1:0]  dx_abs;
  logic signed [ppd_pkg::DIFF_BITS-1:0]  dy_abs;
  logic        [ppd_pkg::COORD_BITS-1:0] ax;
  logic        [ppd_pkg::COORD_BITS-1:0] ay;
  ppd_pkg::ctrl_t                        ctrl_next;

  // Sign-extended differences and their magnitudes
  always_comb begin
    dx = {pair_in.first_x[ppd_pkg::COORD_BITS-1], pair_in.first_x}
       - {pair_in.second_x[ppd_pkg::COORD_BITS-1], pair_in.second_x};
    dy = {pair_in.first_y[ppd_pkg::COORD_BITS-1], pair_in.first_y}
       - {pair_in.second_y[ppd_pkg::COORD_BITS-1], pair_in.second_y};
    dx_abs = dx[ppd_pkg::DIFF_BITS-1] ? -dx : dx;
    dy_abs = dy[ppd_pkg::DIFF_BITS-1] ? -dy : dy;
    ax = dx_abs[ppd_pkg::COORD_BITS-1:0];
    ay = dy_abs[ppd_pkg::COORD_BITS-1:0];

    ctrl_next.ax_zero    = (dx == '0);
    ctrl_next.ay_zero    = (dy == '0);
    ctrl_next.degenerate = ctrl_next.ax_zero && ctrl_next.ay_zero;
    ctrl_next.dx_neg     = dx[ppd_pkg::DIFF_BITS-1];
    ctrl_next.dy_pos     = !dy[ppd_pkg::DIFF_BITS-1] && !ctrl_next.ay_zero;
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl <= ctrl_next;
      x    <= {{(ppd_pkg::CW - ppd_pkg::COORD_BITS - ppd_pkg::FRAC){1'b0}}, ay,
               {ppd_pkg::FRAC{1'b0}}};
      y    <= {{(ppd_pkg::CW - ppd_pkg::COORD_BITS - ppd_pkg::FRAC){1'b0}}, ax,
               {ppd_pkg::FRAC{1'b0}}};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ppd_cordic_stage.sv
// One pipeline stage of CORDIC vectoring, several micro-rotations deep.
`default_nettype none

module ppd_cordic_stage #(
  parameter int FIRST_STEP = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic                          valid_in,
  input  wire ppd_pkg::ctrl_t                ctrl_in,
  input  wire logic signed [ppd_pkg::CW-1:0] x_in,
  input  wire logic signed [ppd_pkg::CW-1:0] y_in,
  input  wire logic signed [ppd_pkg::ZW-1:0] z_in,
  output logic                               valid,
  output ppd_pkg::ctrl_t                     ctrl,
  output logic signed [ppd_pkg::CW-1:0]      x,
  output logic signed [ppd_pkg::CW-1:0]      y,
  output logic signed [ppd_pkg::ZW-1:0]      z
);

  localparam int N = ppd_pkg::STEPS_PER_STAGE;

  logic signed [ppd_pkg::CW-1:0] xs [N+1];
  logic signed [ppd_pkg::CW-1:0] ys [N+1];
  logic signed [ppd_pkg::ZW-1:0] zs [N+1];

  // Micro-rotations: drive y towards zero, accumulate angle
  always_comb begin
    xs[0] = x_in;
    ys[0] = y_in;
    zs[0] = z_in;
    for (int k = 0; k < N; k++) begin
      if (!ys[k][ppd_pkg::CW-1]) begin
        xs[k+1] = xs[k] + (ys[k] >>> (FIRST_STEP + k));
        ys[k+1] = ys[k] - (xs[k] >>> (FIRST_STEP + k));
        zs[k+1] = zs[k] + $signed(ppd_pkg::STEP_ANGLE[FIRST_STEP + k]);
      end else begin
        xs[k+1] = xs[k] - (ys[k] >>> (FIRST_STEP + k));
        ys[k+1] = ys[k] + (xs[k] >>> (FIRST_STEP + k));
        zs[k+1] = zs[k] - $signed(ppd_pkg::STEP_ANGLE[FIRST_STEP + k]);
      end
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctrl <= ctrl_in;
      x    <= xs[N];
      y    <= ys[N];
      z    <= zs[N];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ppd_finish.sv
// Output stage: angle clamp, quadrant rule, rounding and the result register.
`default_nettype none

module ppd_finish (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic                          valid_in,
  input  wire ppd_pkg::ctrl_t                ctrl_in,
  input  wire logic signed [ppd_pkg::ZW-1:0] z_in,
  output logic                               valid,
  output ppd_pkg::heading_t                  result
);

  logic [ppd_pkg::ZW-1:0] a;
  logic [ppd_pkg::ZW-1:0] sum;
  ppd_pkg::heading_t      result_next;

  // Base angle with the axis-aligned cases and the clamp to [0, 90]
  always_comb begin
    priority if (ctrl_in.ax_zero || z_in[ppd_pkg::ZW-1]) begin
      a = '0;
    end else if (ctrl_in.ay_zero || ($unsigned(z_in) > ppd_pkg::A90_Q16)) begin
      a = ppd_pkg::A90_Q16;
    end else begin
      a = $unsigned(z_in);
    end
  end

  // Quadrant rule with the rounding half folded into the constant
  always_comb begin
    priority if (ctrl_in.dx_neg && ctrl_in.dy_pos) begin
      sum = ppd_pkg::HALF_Q16 + a;
    end else if (ctrl_in.dx_neg) begin
      sum = ppd_pkg::D180_ROUND - a;
    end else if (ctrl_in.dy_pos) begin
      sum = ppd_pkg::D360_ROUND - a;
    end else begin
      sum = ppd_pkg::D180_ROUND + a;
    end

    result_next.degenerate  = ctrl_in.degenerate;
    result_next.heading_deg = ctrl_in.degenerate ? '0 :
      sum[ppd_pkg::FRAC + ppd_pkg::HEAD_BITS - 1 : ppd_pkg::FRAC];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/point_pair_heading_degrees.sv
// Registers from an accepted pair to its heading: prep, four CORDIC stages, finish.
// Throughput: one transaction per cycle unless output stalls; 16 CORDIC micro-rotations.
// Each stage loads when it is empty or its successor loads, so bubbles close up
// and input is taken while a finished result waits under stall if a stage is empty.
// Reset (synchronous) empties every stage; no clearing pass is needed.
`default_nettype none

module point_pair_heading_degrees (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pair_valid,
  output logic                   pair_stall,
  input  wire ppd_pkg::pair_t    pair,
  output logic                   heading_valid,
  input  wire logic              heading_stall,
  output ppd_pkg::heading_t      heading
);

  localparam int NCS = ppd_pkg::STEPS / ppd_pkg::STEPS_PER_STAGE;

  logic                          prep_valid;
  ppd_pkg::ctrl_t                prep_ctrl;
  logic signed [ppd_pkg::CW-1:0] prep_x;
  logic signed [ppd_pkg::CW-1:0] prep_y;

  logic                          cs_valid [NCS+1];
  ppd_pkg::ctrl_t                cs_ctrl  [NCS+1];
  logic signed [ppd_pkg::CW-1:0] cs_x     [NCS+1];
  logic signed [ppd_pkg::CW-1:0] cs_y     [NCS+1];
  logic signed [ppd_pkg::ZW-1:0] cs_z     [NCS+1];

  logic                          cs_load  [NCS];
  logic                          prep_load;
  logic                          fin_load;

  // Load enables: a stage advances when empty or when the next one advances
  always_comb begin
    fin_load = !heading_valid || !heading_stall;
    for (int k = NCS - 1; k >= 0; k--) begin
      if (k == NCS - 1) begin
        cs_load[k] = !cs_valid[k+1] || fin_load;
      end else begin
        cs_load[k] = !cs_valid[k+1] || cs_load[k+1];
      end
    end
    prep_load  = !prep_valid || cs_load[0];
    pair_stall = !prep_load;
  end

  ppd_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .load     (prep_load),
    .valid_in (pair_valid),
    .pair_in  (pair),
    .valid    (prep_valid),
    .ctrl     (prep_ctrl),
    .x        (prep_x),
    .y        (prep_y)
  );

  // Seed of the CORDIC chain
  always_comb begin
    cs_valid[0] = prep_valid;
    cs_ctrl[0]  = prep_ctrl;
    cs_x[0]     = prep_x;
    cs_y[0]     = prep_y;
    cs_z[0]     = '0;
  end

  for (genvar g = 0; g < NCS; g++) begin : g_cordic
    ppd_cordic_stage #(
      .FIRST_STEP (g * ppd_pkg::STEPS_PER_STAGE)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .load     (cs_load[g]),
      .valid_in (cs_valid[g]),
      .ctrl_in  (cs_ctrl[g]),
      .x_in     (cs_x[g]),
      .y_in     (cs_y[g]),
      .z_in     (cs_z[g]),
      .valid    (cs_valid[g+1]),
      .ctrl     (cs_ctrl[g+1]),
      .x        (cs_x[g+1]),
      .y        (cs_y[g+1]),
      .z        (cs_z[g+1])
    );
  end

  ppd_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .load     (fin_load),
    .valid_in (cs_valid[NCS]),
    .ctrl_in  (cs_ctrl[NCS]),
    .z_in     (cs_z[NCS]),
    .valid    (heading_valid),
    .result   (heading)
  );

endmodule

`default_nettype wire
